// ===== src/sldc_pkg.sv =====
// ----------------------------------------------------------------------------
// sldc_pkg: shared constants for the sensor linearizer
// Field widths, raw word layout, register map and output mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sldc_pkg;

	// payload field widths
	localparam int RAW_W    = 32;
	localparam int SAMPLE_W = 20;
	localparam int DIST_W   = 12;
	localparam int CODE_W   = 28;
	localparam int INDEX_W  = 4;
	localparam int MODE_W   = 2;

	// raw conversion word layout
	localparam int RAW_ERR_MSB  = 31;
	localparam int RAW_ERR_LSB  = 28;
	localparam int RAW_DATA_MSB = 27;
	localparam int RAW_DATA_LSB = 8;

	// configuration port
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_LOW_DIST  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_DIST = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOW_CODE  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_CODE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd4;

	// register reset values
	localparam logic [DIST_W-1:0] LOW_DIST_RST  = 12'd0;
	localparam logic [DIST_W-1:0] HIGH_DIST_RST = 12'd2560;
	localparam logic [CODE_W-1:0] LOW_CODE_RST  = 28'hD800000;
	localparam logic [CODE_W-1:0] HIGH_CODE_RST = 28'h5280000;

	// output mode codes; the unused code behaves as normal mapping
	localparam logic [MODE_W-1:0] MODE_NORMAL     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FORCE_LOW  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FORCE_HIGH = 2'd2;

	// input item actions
	localparam logic ACT_CONVERT = 1'b0;
	localparam logic ACT_WRITE   = 1'b1;

	localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

endpackage

`default_nettype wire

// ===== src/sldc_if.sv =====
// ----------------------------------------------------------------------------
// sldc_if: item channels of the sensor linearizer
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sldc_in_if;
	logic                             valid;
	logic                             ready;
	logic                             action;
	logic [sldc_pkg::RAW_W-1:0]       raw_word;
	logic [sldc_pkg::INDEX_W-1:0]     entry_index;
	logic [sldc_pkg::SAMPLE_W-1:0]    entry_value;

	modport source (output valid, action, raw_word, entry_index, entry_value, input ready);
	modport sink   (input valid, action, raw_word, entry_index, entry_value, output ready);
endinterface

interface sldc_out_if;
	logic                             valid;
	logic                             ready;
	logic [sldc_pkg::SAMPLE_W-1:0]    sensor_value;
	logic [sldc_pkg::DIST_W-1:0]      distance_q8;
	logic [sldc_pkg::CODE_W-1:0]      dac_code;
	logic                             raw_error;
	logic                             span_error;

	modport source (output valid, sensor_value, distance_q8, dac_code, raw_error, span_error,
		input ready);
	modport sink   (input valid, sensor_value, distance_q8, dac_code, raw_error, span_error,
		output ready);
endinterface

`default_nettype wire

// ===== src/sensor_linearizer_to_dac_code_top.sv =====
// ----------------------------------------------------------------------------
// sensor_linearizer_to_dac_code_top: sensor linearizer to DAC code
// Scans a descending calibration table, interpolates a distance in table
// steps and maps it linearly onto a saturated 28-bit DAC code, or outputs the low or high code when forced.
// ----------------------------------------------------------------------------
//
//   channel     dir   kind          carries
//   sample_in   in    valid/ready   action, raw_word, entry_index, entry_value
//   result_out  out   valid/ready   sensor_value, distance_q8, dac_code, flags
//   APB         in    psel/penable  register writes and reads, pready tied high
//
// A table write gives no result. A conversion reads and compares the table
// entries one at a time (at most TABLE_ENTRIES of them), then, when the
// sample lies between two entries, runs the interpolation division, then for
// normal mapping a multiply and a serial division of the product (40 bits by
// default), one quotient bit at a time, before the result is registered.
// All divisions share one serial divider; the table is read one entry at a time.
// The block takes a new item only when idle, and holds a finished result in
// its output register until the sink takes it. Reset leaves the table reading
// as zeros, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_linearizer_to_dac_code_top #(
	parameter int TABLE_ENTRIES = 16,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sldc_in_if.sink                            sample_in,
	sldc_out_if.source                         result_out,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sldc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [sldc_pkg::APB_DW-1:0]   pwdata,
	output      logic [sldc_pkg::APB_DW-1:0]   prdata,
	output      logic                          pready
);

	localparam int SW     = sldc_pkg::SAMPLE_W;
	localparam int CDW    = sldc_pkg::CODE_W;
	localparam int DOW    = sldc_pkg::DIST_W;
	localparam int IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int DISTW  = IW + FRACTION_BITS;
	localparam int AW     = (DISTW > DOW) ? DISTW : DOW;
	localparam int PW     = AW + CDW;
	localparam int CW     = $clog2(PW + 1);
	localparam int MW     = PW + 1;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CMP  = 4'd2;
	localparam logic [3:0] S_DIV1 = 4'd3;
	localparam logic [3:0] S_MAP  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DIV2 = 4'd6;
	localparam logic [3:0] S_SAT  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]                      state_q;

	// configuration registers
	logic [DOW-1:0]                  low_distance_q;
	logic [DOW-1:0]                  high_distance_q;
	logic [CDW-1:0]                  low_code_q;
	logic [CDW-1:0]                  high_code_q;
	logic [sldc_pkg::MODE_W-1:0]     output_mode_q;
	logic                            cfg_wr;
	logic [sldc_pkg::REG_IDX_W-1:0]  cfg_idx;

	// working registers
	logic [SW-1:0]                   sample_q;
	logic                            raw_err_q;
	logic [IW-1:0]                   idx_q;
	logic [SW-1:0]                   prev_q;
	logic [DISTW-1:0]                dist_q;
	logic [AW-1:0]                   a_q;
	logic [CDW-1:0]                  b_q;
	logic [SW-1:0]                   den_q;
	logic                            neg_q;
	logic [MW-1:0]                   mag_q;
	logic [CDW-1:0]                  code_q;
	logic                            span_q;

	// output register
	logic                            out_valid_q;
	logic [SW-1:0]                   out_sample_q;
	logic [DOW-1:0]                  out_dist_q;
	logic [CDW-1:0]                  out_code_q;
	logic                            out_raw_err_q;
	logic                            out_span_err_q;

	// table and divider connections
	logic                            tbl_wr;
	logic [IW-1:0]                   tbl_wr_addr;
	logic [SW-1:0]                   tbl_rd_data;
	logic                            div_start;
	logic [PW-1:0]                   div_dividend;
	logic [SW-1:0]                   div_rem_init;
	logic [SW-1:0]                   div_divisor;
	logic [CW-1:0]                   div_steps;
	logic                            div_done;
	logic [PW-1:0]                   div_quo;
	logic [SW-1:0]                   div_rem;

	logic                            in_xfer;
	logic                            out_load;
	logic                            raw_bad;
	logic                            entry_le;
	logic [SW-1:0]                   gap_above;
	logic [AW-1:0]                   d_ext;
	logic [AW-1:0]                   ld_ext;
	logic [DISTW-1:0]                dist_interp;
	logic [MW-1:0]                   sat_sum;
	logic [CDW-1:0]                  sat_code;

	sldc_cal_table #(
		.ENTRIES (TABLE_ENTRIES),
		.AW      (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr),
		.wr_addr (tbl_wr_addr),
		.wr_data (sample_in.entry_value),
		.rd_addr (idx_q),
		.rd_data (tbl_rd_data)
	);

	sldc_divider #(
		.NW  (PW),
		.DVW (SW),
		.CW  (CW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.rem_init  (div_rem_init),
		.divisor   (div_divisor),
		.steps     (div_steps),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// handshake and table write decode
	assign sample_in.ready = (state_q == S_IDLE);
	assign in_xfer         = sample_in.valid && sample_in.ready;
	assign tbl_wr          = in_xfer && (sample_in.action == sldc_pkg::ACT_WRITE) &&
		(32'(sample_in.entry_index) < TABLE_ENTRIES);
	assign tbl_wr_addr     = IW'(sample_in.entry_index);
	assign raw_bad         = sample_in.raw_word[sldc_pkg::RAW_ERR_MSB:sldc_pkg::RAW_ERR_LSB] != '0;
	assign out_load        = (state_q == S_FIN) && (!out_valid_q || result_out.ready);

	// scan compare and interpolation terms
	always_comb begin
		entry_le    = tbl_rd_data <= sample_q;
		gap_above   = prev_q - sample_q;
		dist_interp = DISTW'({idx_q - IW'(1), {FRACTION_BITS{1'b0}}}) +
			DISTW'(div_quo[FRACTION_BITS:0]);
		d_ext       = AW'(dist_q);
		ld_ext      = AW'(low_distance_q);
	end

	// start the shared divider for interpolation or for mapping
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_rem_init = '0;
		div_divisor  = '0;
		div_steps    = '0;
		if (state_q == S_CMP && entry_le && idx_q != '0) begin
			div_start    = 1'b1;
			div_dividend = {gap_above[0], {(PW-1){1'b0}}};
			div_rem_init = {1'b0, gap_above[SW-1:1]};
			div_divisor  = prev_q - tbl_rd_data;
			div_steps    = CW'(FRACTION_BITS + 1);
		end else if (state_q == S_MUL) begin
			div_start    = 1'b1;
			div_dividend = PW'(a_q) * PW'(b_q);
			div_rem_init = '0;
			div_divisor  = den_q;
			div_steps    = CW'(PW);
		end
	end

	// add or subtract the scaled step and saturate
	always_comb begin
		sat_sum = MW'(low_code_q) + mag_q;
		if (neg_q) begin
			sat_code = (mag_q > MW'(low_code_q)) ? '0 : (low_code_q - mag_q[CDW-1:0]);
		end else if (sat_sum > MW'(sldc_pkg::CODE_MAX)) begin
			sat_code = sldc_pkg::CODE_MAX;
		end else begin
			sat_code = sat_sum[CDW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer && sample_in.action == sldc_pkg::ACT_CONVERT) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (entry_le) begin
						state_q <= (idx_q == '0) ? S_MAP : S_DIV1;
					end else if (idx_q == IW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_MAP;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					if (output_mode_q == sldc_pkg::MODE_FORCE_LOW ||
						output_mode_q == sldc_pkg::MODE_FORCE_HIGH ||
						low_distance_q == high_distance_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// last good sample and error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q  <= '0;
			raw_err_q <= 1'b0;
		end else if (in_xfer && sample_in.action == sldc_pkg::ACT_CONVERT) begin
			raw_err_q <= raw_bad;
			if (!raw_bad) begin
				sample_q <= sample_in.raw_word[sldc_pkg::RAW_DATA_MSB:sldc_pkg::RAW_DATA_LSB];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q <= '0;
			end
			S_CMP: begin
				if (entry_le) begin
					if (idx_q == '0) begin
						dist_q <= '0;
					end
				end else begin
					prev_q <= tbl_rd_data;
					if (idx_q == IW'(TABLE_ENTRIES - 1)) begin
						dist_q <= {IW'(TABLE_ENTRIES - 1), {FRACTION_BITS{1'b0}}};
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
			end
			S_DIV1: begin
				if (div_done) begin
					dist_q <= dist_interp;
				end
			end
			S_MAP: begin
				a_q    <= (d_ext >= ld_ext) ? (d_ext - ld_ext) : (ld_ext - d_ext);
				b_q    <= (high_code_q >= low_code_q) ? (high_code_q - low_code_q) :
					(low_code_q - high_code_q);
				den_q  <= SW'((high_distance_q >= low_distance_q) ?
					(high_distance_q - low_distance_q) : (low_distance_q - high_distance_q));
				neg_q  <= (d_ext < ld_ext) ^ (high_code_q < low_code_q) ^
					(high_distance_q < low_distance_q);
				span_q <= 1'b0;
				case (output_mode_q)
					sldc_pkg::MODE_FORCE_LOW: begin
						code_q <= low_code_q;
					end
					sldc_pkg::MODE_FORCE_HIGH: begin
						code_q <= high_code_q;
					end
					default: begin
						code_q <= low_code_q;
						span_q <= (low_distance_q == high_distance_q);
					end
				endcase
			end
			S_DIV2: begin
				if (div_done) begin
					mag_q <= MW'(div_quo) + MW'(neg_q && div_rem != '0);
				end
			end
			S_SAT: begin
				code_q <= sat_code;
			end
			default: begin
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q   <= sample_q;
			out_dist_q     <= DOW'(dist_q);
			out_code_q     <= code_q;
			out_raw_err_q  <= raw_err_q;
			out_span_err_q <= span_q;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.sensor_value = out_sample_q;
	assign result_out.distance_q8  = out_dist_q;
	assign result_out.dac_code     = out_code_q;
	assign result_out.raw_error    = out_raw_err_q;
	assign result_out.span_error   = out_span_err_q;

	// configuration writes
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[sldc_pkg::APB_AW-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_distance_q  <= sldc_pkg::LOW_DIST_RST;
			high_distance_q <= sldc_pkg::HIGH_DIST_RST;
			low_code_q      <= sldc_pkg::LOW_CODE_RST;
			high_code_q     <= sldc_pkg::HIGH_CODE_RST;
			output_mode_q   <= sldc_pkg::MODE_NORMAL;
		end else if (cfg_wr) begin
			case (cfg_idx)
				sldc_pkg::REG_LOW_DIST:  low_distance_q  <= pwdata[DOW-1:0];
				sldc_pkg::REG_HIGH_DIST: high_distance_q <= pwdata[DOW-1:0];
				sldc_pkg::REG_LOW_CODE:  low_code_q      <= pwdata[CDW-1:0];
				sldc_pkg::REG_HIGH_CODE: high_code_q     <= pwdata[CDW-1:0];
				sldc_pkg::REG_MODE:      output_mode_q   <= pwdata[sldc_pkg::MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (cfg_idx)
			sldc_pkg::REG_LOW_DIST:  prdata = sldc_pkg::APB_DW'(low_distance_q);
			sldc_pkg::REG_HIGH_DIST: prdata = sldc_pkg::APB_DW'(high_distance_q);
			sldc_pkg::REG_LOW_CODE:  prdata = sldc_pkg::APB_DW'(low_code_q);
			sldc_pkg::REG_HIGH_CODE: prdata = sldc_pkg::APB_DW'(high_code_q);
			sldc_pkg::REG_MODE:      prdata = sldc_pkg::APB_DW'(output_mode_q);
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sldc_cal_table.sv =====
// ----------------------------------------------------------------------------
// sldc_cal_table: calibration table store
// One write port, one registered read port; per-entry valid bits make
// entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sldc_cal_table #(
	parameter int ENTRIES = 16,
	parameter int AW      = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [sldc_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic [AW-1:0]                 rd_addr,
	output      logic [sldc_pkg::SAMPLE_W-1:0] rd_data
);

	logic [sldc_pkg::SAMPLE_W-1:0] mem [ENTRIES];
	logic [sldc_pkg::SAMPLE_W-1:0] rd_raw_q;
	logic [ENTRIES-1:0]            valid_q;
	logic                          rd_valid_q;

	// write and read the array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	// track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// unwritten entries read as zero
	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

// ===== src/sldc_divider.sv =====
// ----------------------------------------------------------------------------
// sldc_divider: shared serial divider
// Restoring division, one quotient bit per cycle; the caller sets the
// starting remainder and the number of dividend bits to shift through.
// ----------------------------------------------------------------------------
`default_nettype none

module sldc_divider #(
	parameter int NW  = 40,
	parameter int DVW = 20,
	parameter int CW  = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [NW-1:0]  dividend,
	input  wire logic [DVW-1:0] rem_init,
	input  wire logic [DVW-1:0] divisor,
	input  wire logic [CW-1:0]  steps,
	output      logic           done,
	output      logic [NW-1:0]  quotient,
	output      logic [DVW-1:0] remainder
);

	logic [DVW-1:0] rem_q;
	logic [NW-1:0]  quo_q;
	logic [DVW-1:0] dvs_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DVW:0]   trial;
	logic [DVW:0]   trial_diff;
	logic           trial_ge;

	// one trial subtraction per cycle
	always_comb begin
		trial      = {rem_q, quo_q[NW-1]};
		trial_diff = trial - {1'b0, dvs_q};
		trial_ge   = trial >= {1'b0, dvs_q};
	end

	// load operands or advance one bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= trial_ge ? trial_diff[DVW-1:0] : trial[DVW-1:0];
			quo_q <= {quo_q[NW-2:0], trial_ge};
		end
	end

	// step count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== src/sldc_checker.sv =====
// ----------------------------------------------------------------------------
// sldc_checker: port-level checks for the sensor linearizer
// Watches the item channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sldc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          in_action,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [sldc_pkg::CODE_W-1:0]   out_dac_code
);

	// a conversion holds the block busy for at least the next cycle
	a_busy_after_convert: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_action == sldc_pkg::ACT_CONVERT) |=> !in_ready)
		else $error("input taken right after a conversion transfer");

	// a new result appears only at the end of a busy period
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a conversion in progress");

	// a table write gives no result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_action == sldc_pkg::ACT_WRITE) |=> !$rose(out_valid))
		else $error("table write produced a result");

	// a stalled result holds its code
	a_code_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_dac_code)))
		else $error("stalled result changed");

endmodule

bind sensor_linearizer_to_dac_code_top sldc_checker u_sldc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample_in.valid),
	.in_ready     (sample_in.ready),
	.in_action    (sample_in.action),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.out_dac_code (result_out.dac_code)
);

`default_nettype wire

// ===== verif/sldc_code_check.sv =====
// ----------------------------------------------------------------------------
// sldc_code_check: result checker for the sensor linearizer
// Watches the item channels and the register port, keeps its own copy of
// the calibration table, the last good sample and the span registers, works
// out each expected DAC result and compares it field by field with the
// result transfers, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module sldc_code_check #(
	parameter int TABLE_ENTRIES = 16,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sldc_in_if                                 in_ch,
	sldc_out_if                                out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic                          pready,
	input  wire logic [sldc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [sldc_pkg::APB_DW-1:0]   pwdata,
	output int                                 mismatches,
	output int                                 awaiting
);
	import sldc_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sensor_value;
		logic [DIST_W-1:0]   distance_q8;
		logic [CODE_W-1:0]   dac_code;
		logic                raw_error;
		logic                span_error;
	} dac_result_t;

	// mirrored block state
	logic [SAMPLE_W-1:0] cal_table [TABLE_ENTRIES];
	logic [SAMPLE_W-1:0] good_sample;
	logic [DIST_W-1:0]   low_dist, high_dist;
	logic [CODE_W-1:0]   low_code, high_code;
	logic [MODE_W-1:0]   out_mode;

	dac_result_t pending_codes [$];

	// first entry not above the sample, then interpolate against the one before
	function automatic longint unsigned scan_distance(input logic [SAMPLE_W-1:0] s);
		int i;
		longint unsigned above, below;
		i = 0;
		while (i < TABLE_ENTRIES && cal_table[i] > s)
			i++;
		if (i == 0)
			return 0;
		if (i >= TABLE_ENTRIES)
			return longint'(TABLE_ENTRIES - 1) << FRACTION_BITS;
		above = longint'(cal_table[i-1]);
		below = longint'(cal_table[i]);
		return (longint'(i - 1) << FRACTION_BITS) +
			(((above - longint'(s)) << FRACTION_BITS) / (above - below));
	endfunction

	// exact linear map with floor division, then clamp to the code range
	function automatic logic [CODE_W-1:0] map_span(input longint d);
		longint num, den, q, v;
		num = (d - longint'(low_dist)) * (longint'(high_code) - longint'(low_code));
		den = longint'(high_dist) - longint'(low_dist);
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		q = num / den;
		if (num % den != 0 && num < 0)
			q--;
		v = longint'(low_code) + q;
		if (v < 0)
			v = 0;
		if (v > longint'(CODE_MAX))
			v = longint'(CODE_MAX);
		return v[CODE_W-1:0];
	endfunction

	function automatic dac_result_t predict_code(input logic [RAW_W-1:0] raw);
		dac_result_t r;
		longint unsigned scan_q8;
		r = '0;
		if (raw[RAW_ERR_MSB:RAW_ERR_LSB] == '0)
			good_sample = raw[RAW_DATA_MSB:RAW_DATA_LSB];
		else
			r.raw_error = 1'b1;
		scan_q8 = scan_distance(good_sample);
		r.sensor_value = good_sample;
		r.distance_q8 = scan_q8[DIST_W-1:0];
		if (out_mode == MODE_FORCE_LOW) begin
			r.dac_code = low_code;
		end else if (out_mode == MODE_FORCE_HIGH) begin
			r.dac_code = high_code;
		end else if (low_dist == high_dist) begin
			r.dac_code = low_code;
			r.span_error = 1'b1;
		end else begin
			r.dac_code = map_span(longint'(scan_q8));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input dac_result_t want,
			input dac_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected sensor %h dist %h code %h raw_err %b span_err %b, %s",
				what, want.sensor_value, want.distance_q8, want.dac_code,
				want.raw_error, want.span_error,
				$sformatf("got sensor %h dist %h code %h raw_err %b span_err %b",
				got.sensor_value, got.distance_q8, got.dac_code,
				got.raw_error, got.span_error));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		dac_result_t got, want;
		if (!arst_n) begin
			for (int k = 0; k < TABLE_ENTRIES; k++)
				cal_table[k] = '0;
			good_sample = '0;
			low_dist = LOW_DIST_RST;
			high_dist = HIGH_DIST_RST;
			low_code = LOW_CODE_RST;
			high_code = HIGH_CODE_RST;
			out_mode = MODE_NORMAL;
			pending_codes.delete();
			mismatches = 0;
			awaiting <= 0;
		end else begin
			// follow register writes, masked to the register widths
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_LOW_DIST:  low_dist = pwdata[DIST_W-1:0];
					REG_HIGH_DIST: high_dist = pwdata[DIST_W-1:0];
					REG_LOW_CODE:  low_code = pwdata[CODE_W-1:0];
					REG_HIGH_CODE: high_code = pwdata[CODE_W-1:0];
					REG_MODE:      out_mode = pwdata[MODE_W-1:0];
					default: ;
				endcase
			end

			// check a result transfer against the oldest expectation
			if (out_ch.valid && out_ch.ready) begin
				got.sensor_value = out_ch.sensor_value;
				got.distance_q8 = out_ch.distance_q8;
				got.dac_code = out_ch.dac_code;
				got.raw_error = out_ch.raw_error;
				got.span_error = out_ch.span_error;
				if (pending_codes.size() == 0) begin
					report_mismatch("unexpected result", '0, got);
				end else begin
					want = pending_codes.pop_front();
					if (got.sensor_value !== want.sensor_value ||
							got.distance_q8 !== want.distance_q8 ||
							got.dac_code !== want.dac_code ||
							got.raw_error !== want.raw_error ||
							got.span_error !== want.span_error)
						report_mismatch("result mismatch", want, got);
				end
			end

			// table writes update the mirror, conversions queue a prediction
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.action == ACT_WRITE) begin
					if (int'(in_ch.entry_index) < TABLE_ENTRIES)
						cal_table[in_ch.entry_index] = in_ch.entry_value;
				end else begin
					pending_codes.push_back(predict_code(in_ch.raw_word));
				end
			end

			awaiting <= pending_codes.size();
		end
	end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for sensor_linearizer_to_dac_code_top
// Loads calibration ramps, converts samples on, between and beyond the
// entries, and walks the span registers through normal, reversed, equal,
// saturating and forced settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import sldc_pkg::*;

	localparam int TABLE_ENTRIES = 16;
	localparam int FRACTION_BITS = 8;
	localparam int SETTLE_CYCLES = 128;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int BATCH_ITEMS   = 135;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	int                  mismatches, awaiting;
	bit                  calm;

	// copy of the table contents, used only to aim samples at it
	logic [SAMPLE_W-1:0] cal_copy [TABLE_ENTRIES];

	sldc_in_if  sample_ch ();
	sldc_out_if result_ch ();

	sensor_linearizer_to_dac_code_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_in(sample_ch),
		.result_out(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	sldc_code_check #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRACTION_BITS(FRACTION_BITS)
	) code_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(sample_ch),
		.out_ch(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.awaiting(awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop for a hung run
	initial begin
		#8_000_000;
		$display("sensor_linearizer_to_dac_code_top verification failed");
		$finish;
	end

	// result side: stall a random number of cycles before each transfer
	initial begin : result_sink
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_span(input logic [APB_DW-1:0] lo_dist, input logic [APB_DW-1:0] hi_dist,
			input logic [APB_DW-1:0] lo_code, input logic [APB_DW-1:0] hi_code,
			input logic [APB_DW-1:0] mode);
		reg_write(REG_LOW_DIST, lo_dist);
		reg_write(REG_HIGH_DIST, hi_dist);
		reg_write(REG_LOW_CODE, lo_code);
		reg_write(REG_HIGH_CODE, hi_code);
		reg_write(REG_MODE, mode);
	endtask

	// one item transfer after a random gap; valid stays high when there is no gap
	task automatic send_item(input logic act, input logic [RAW_W-1:0] raw,
			input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.action <= act;
		sample_ch.raw_word <= raw;
		sample_ch.entry_index <= idx;
		sample_ch.entry_value <= val;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		send_item(ACT_WRITE, $urandom, idx, val);
		cal_copy[idx] = val;
	endtask

	task automatic convert(input logic [RAW_W-1:0] raw);
		send_item(ACT_CONVERT, raw, INDEX_W'($urandom), SAMPLE_W'($urandom));
	endtask

	function automatic logic [RAW_W-1:0] sample_word(input logic [SAMPLE_W-1:0] s);
		return {4'h0, s, 8'($urandom)};
	endfunction

	// aim at an entry, between two entries, beyond the ends, or anywhere
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int k;
		k = $urandom_range(0, TABLE_ENTRIES - 1);
		case ($urandom_range(0, 9))
			0: return cal_copy[k];
			1: return SAMPLE_W'($urandom_range(cal_copy[0], 20'hFFFFF));
			2: return SAMPLE_W'($urandom);
			default: return SAMPLE_W'($urandom_range(cal_copy[k],
				(k == TABLE_ENTRIES - 1) ? 20'd0 : cal_copy[k+1]));
		endcase
	endfunction

	// fill the table with a fresh descending ramp, flat steps allowed
	task automatic load_ramp();
		int level, max_step, step;
		level = $urandom_range(20'h40000, 20'hFFFFF);
		max_step = $urandom_range(1, 70000);
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			write_entry(INDEX_W'(k), SAMPLE_W'(level));
			step = $urandom_range(0, max_step);
			level = (level > step) ? level - step : 0;
		end
	endtask

	// mostly clean samples near the ramp, some errors, stray writes and noise
	task automatic random_batch(input int n);
		int roll;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 6)
				write_entry(INDEX_W'($urandom), SAMPLE_W'($urandom));
			else if (roll < 12)
				convert($urandom);
			else if (roll < 22)
				convert({4'($urandom_range(1, 15)), 28'($urandom)});
			else
				convert(sample_word(pick_sample()));
		end
	endtask

	// hold the sender until every result is back and the block is quiet
	task automatic settle();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int guard;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.action <= ACT_CONVERT;
		sample_ch.raw_word <= '0;
		sample_ch.entry_index <= '0;
		sample_ch.entry_value <= '0;
		calm = 1'b0;
		for (int k = 0; k < TABLE_ENTRIES; k++)
			cal_copy[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: the sample sits at the first entry
		convert(32'h0000_0000);
		// fixed ramp, then samples above, on, between and below the entries
		for (int k = 0; k < TABLE_ENTRIES; k++)
			write_entry(INDEX_W'(k), SAMPLE_W'(20'hF0000 - k * 20'h0F000));
		convert(sample_word(20'hFFFFF));
		convert(sample_word(20'hF0000));
		convert(sample_word(20'hE1000));
		convert(sample_word(20'h80800));
		convert(sample_word(20'h0F000));
		convert(sample_word(20'h00000));
		// error nibble: previous sample reused, then a clean word
		convert(32'hF000_0000);
		convert(32'h1FFF_FFFF);
		convert(32'hFFFF_FFFF);
		convert(32'h0FFF_FFFF);
		// extreme entry values out of order
		write_entry(4'hF, 20'hFFFFF);
		convert(sample_word(20'h10000));
		write_entry(4'h0, 20'h00000);
		convert(sample_word(20'h00000));

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			case (ph)
				1: set_span(0, 3840, CODE_MAX, 0, MODE_NORMAL);
				2: set_span(3840, 0, 0, CODE_MAX, MODE_NORMAL);
				3: set_span(1000, 1000, $urandom_range(0, CODE_MAX),
					$urandom_range(0, CODE_MAX), MODE_NORMAL);
				4: set_span($urandom_range(0, 3840), $urandom_range(0, 3840),
					$urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
					MODE_FORCE_LOW);
				5: set_span($urandom_range(0, 3840), $urandom_range(0, 3840),
					$urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
					MODE_FORCE_HIGH);
				6: set_span($urandom_range(0, 3840), $urandom_range(0, 3840),
					$urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
					MODE_SPARE);
				7: set_span(2000, 2001, 0, CODE_MAX, MODE_NORMAL);
				8: begin
					// bits above each register width must be dropped
					set_span(32'hFFFF_FFFF, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hF000_0000,
						32'hFFFF_FFFC);
					reg_write(REG_UNUSED, $urandom);
				end
				9: set_span($urandom_range(0, 3840), $urandom_range(0, 3840),
					$urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
					MODE_NORMAL);
				default: ;
			endcase
			calm = (ph == 4 || ph == 9);
			load_ramp();
			random_batch(BATCH_ITEMS);
		end

		// drain, bounded, then let the pipeline go quiet
		sample_ch.valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (awaiting != 0 && guard < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaiting == 0)
			$display("sensor_linearizer_to_dac_code_top verification clean");
		else
			$display("sensor_linearizer_to_dac_code_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire
